// ===== sv/assert_macros.svh =====
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on i_clk, quiet during reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge while out of reset.
`define ASSERT_PROP(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// The expression must never be true while out of reset.
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);

`endif

// ===== sv/ctfe_pkg.sv =====
// -----------------------------------------------------------------------------
// Calendar time field editor package
// Item types, field limits, unit codes and calendar helper functions.
// -----------------------------------------------------------------------------
package ctfe_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD  = 2'd0,
        MODE_UP    = 2'd1,
        MODE_DOWN  = 2'd2,
        MODE_ENTER = 2'd3
    } t_mode;

    typedef logic [2:0] t_unit;
    typedef logic [6:0] t_value;

    localparam t_unit UNIT_YEAR    = 3'd0;
    localparam t_unit UNIT_MONTH   = 3'd1;
    localparam t_unit UNIT_DATE    = 3'd2;
    localparam t_unit UNIT_WEEKDAY = 3'd3;
    localparam t_unit UNIT_HOUR    = 3'd4;
    localparam t_unit UNIT_MINUTE  = 3'd5;
    localparam t_unit UNIT_SECOND  = 3'd6;

    localparam logic [6:0] YEAR_MAX    = 7'd99;
    localparam logic [3:0] MONTH_MAX   = 4'd12;
    localparam logic [4:0] DATE_MAX    = 5'd31;
    localparam logic [2:0] WEEKDAY_MAX = 3'd7;
    localparam logic [4:0] HOUR_MAX    = 5'd23;
    localparam logic [5:0] MINUTE_MAX  = 6'd59;
    localparam logic [5:0] SECOND_MAX  = 6'd59;
    localparam logic [3:0] MONTH_FEB   = 4'd2;
    localparam logic [4:0] FEB_LEAP    = 5'd29;
    localparam logic [4:0] FEB_COMMON  = 5'd28;

    typedef struct packed {
        t_mode      mode;
        logic [6:0] load_year;
        logic [3:0] load_month;
        logic [4:0] load_date;
        logic [2:0] load_weekday;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
    } t_in_item;

    typedef struct packed {
        t_unit      selected_unit;
        t_value     selected_value;
        logic [4:0] working_date;
        logic       committed;
        t_unit      committed_unit;
        t_value     committed_value;
    } t_out_item;

    // One set of the seven calendar fields, each at its own width.
    typedef struct packed {
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] date;
        logic [2:0] weekday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_fields;

    function automatic t_value unit_max(input t_unit u);
        t_value m;
        case (u)
            UNIT_YEAR:    m = YEAR_MAX;
            UNIT_MONTH:   m = 7'(MONTH_MAX);
            UNIT_DATE:    m = 7'(DATE_MAX);
            UNIT_WEEKDAY: m = 7'(WEEKDAY_MAX);
            UNIT_HOUR:    m = 7'(HOUR_MAX);
            UNIT_MINUTE:  m = 7'(MINUTE_MAX);
            default:      m = 7'(SECOND_MAX);
        endcase
        return m;
    endfunction

    // Month length; leap years are those divisible by four within the century.
    // Month codes outside one to twelve count as 31 days.
    function automatic logic [4:0] days_in(input logic [3:0] month, input logic [6:0] year);
        logic [4:0] d;
        case (month)
            4'd2:                       d = (year[1:0] == 2'b00) ? FEB_LEAP : FEB_COMMON;
            4'd4, 4'd6, 4'd9, 4'd11:    d = 5'd30;
            default:                    d = DATE_MAX;
        endcase
        return d;
    endfunction

    function automatic t_value field_get(input t_fields f, input t_unit u);
        t_value v;
        case (u)
            UNIT_YEAR:    v = f.year;
            UNIT_MONTH:   v = 7'(f.month);
            UNIT_DATE:    v = 7'(f.date);
            UNIT_WEEKDAY: v = 7'(f.weekday);
            UNIT_HOUR:    v = 7'(f.hour);
            UNIT_MINUTE:  v = 7'(f.minute);
            default:      v = 7'(f.second);
        endcase
        return v;
    endfunction

    function automatic t_fields field_set(input t_fields f, input t_unit u, input t_value v);
        t_fields r;
        r = f;
        case (u)
            UNIT_YEAR:    r.year    = v;
            UNIT_MONTH:   r.month   = v[3:0];
            UNIT_DATE:    r.date    = v[4:0];
            UNIT_WEEKDAY: r.weekday = v[2:0];
            UNIT_HOUR:    r.hour    = v[4:0];
            UNIT_MINUTE:  r.minute  = v[5:0];
            default:      r.second  = v[5:0];
        endcase
        return r;
    endfunction

endpackage

// ===== sv/ctfe_editor.sv =====
// -----------------------------------------------------------------------------
// Calendar time field editor core
// Holds working and committed fields and the selection; applies one event.
// -----------------------------------------------------------------------------
module ctfe_editor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  ctfe_pkg::t_in_item  i_item,
    output ctfe_pkg::t_out_item o_result
);
    import ctfe_pkg::*;

    t_fields r_work, n_work;
    t_fields r_comm, n_comm;
    t_unit   r_sel,  n_sel;

    t_value     cur_val;
    t_value     max_val;
    t_value     up_val;
    t_value     down_val;
    t_value     step_val;
    logic [4:0] md_now;
    logic [4:0] md_new;

    always_comb begin
        cur_val = field_get(r_work, r_sel);
        max_val = unit_max(r_sel);
        md_now  = days_in(r_work.month, r_work.year);

        // Up wraps to the lowest value; date also wraps past the month length.
        up_val = (cur_val >= max_val) ? '0 : cur_val + 7'd1;
        if (r_sel == UNIT_DATE && (up_val == '0 || up_val > 7'(md_now))) begin
            up_val = 7'd1;
        end
        if ((r_sel == UNIT_WEEKDAY || r_sel == UNIT_MONTH) && up_val == '0) begin
            up_val = 7'd1;
        end

        down_val = (cur_val == '0) ? max_val : cur_val - 7'd1;
        if (down_val == '0) begin
            case (r_sel)
                UNIT_DATE:    down_val = 7'(md_now);
                UNIT_WEEKDAY: down_val = 7'(WEEKDAY_MAX);
                UNIT_MONTH:   down_val = 7'(MONTH_MAX);
                default:      down_val = '0;
            endcase
        end

        step_val = (i_item.mode == MODE_UP) ? up_val : down_val;
        md_new   = days_in(step_val[3:0], r_work.year);

        n_work = r_work;
        n_comm = r_comm;
        n_sel  = r_sel;
        o_result = '0;

        case (i_item.mode)
            MODE_LOAD: begin
                n_work.year    = (i_item.load_year > YEAR_MAX) ? YEAR_MAX : i_item.load_year;
                n_work.month   = (i_item.load_month == '0) ? 4'd1 :
                                 (i_item.load_month > MONTH_MAX) ? MONTH_MAX : i_item.load_month;
                n_work.date    = (i_item.load_date == '0) ? 5'd1 : i_item.load_date;
                n_work.weekday = (i_item.load_weekday == '0) ? 3'd1 : i_item.load_weekday;
                n_work.hour    = (i_item.load_hour > HOUR_MAX) ? HOUR_MAX : i_item.load_hour;
                n_work.minute  = (i_item.load_minute > MINUTE_MAX) ? MINUTE_MAX
                                                                   : i_item.load_minute;
                n_work.second  = (i_item.load_second > SECOND_MAX) ? SECOND_MAX
                                                                   : i_item.load_second;
                n_comm = n_work;
                n_sel  = UNIT_YEAR;
            end
            MODE_UP, MODE_DOWN: begin
                n_work = field_set(r_work, r_sel, step_val);
                // A new month pulls the date down to that month's length.
                if (r_sel == UNIT_MONTH && n_work.date > md_new) begin
                    n_work.date = md_new;
                end
                // A new common year turns 29 February into the 28th.
                if (r_sel == UNIT_YEAR && r_work.month == MONTH_FEB &&
                    r_work.date == FEB_LEAP && step_val[1:0] != 2'b00) begin
                    n_work.date = FEB_COMMON;
                end
            end
            default: begin
                n_comm = field_set(r_comm, r_sel, cur_val);
                n_sel  = (r_sel == UNIT_SECOND) ? UNIT_YEAR : r_sel + 3'd1;
                o_result.committed       = 1'b1;
                o_result.committed_unit  = r_sel;
                o_result.committed_value = cur_val;
            end
        endcase

        o_result.selected_unit  = n_sel;
        o_result.selected_value = field_get(n_work, n_sel);
        o_result.working_date   = n_work.date;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_work <= '0;
            r_comm <= '0;
            r_sel  <= UNIT_YEAR;
        end else if (i_fire) begin
            r_work <= n_work;
            r_comm <= n_comm;
            r_sel  <= n_sel;
        end
    end

endmodule

// ===== sv/calendar_time_field_editor.sv =====
// -----------------------------------------------------------------------------
// Calendar time field editor: button events edit seven date and time fields.
// Path: an accepted item passes from the input register through the field update
// into the result register, which offers it as a result.
// Throughput: one item per cycle while the receiver does not stall.
// Reset: synchronous, active low; all fields zero, year selected, both stages empty.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module calendar_time_field_editor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  ctfe_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output ctfe_pkg::t_out_item o_item
);
    import ctfe_pkg::*;

    // Input stage: each accepted item is captured here first.
    logic      r_in_valid, n_in_valid;
    t_in_item  r_in_item;

    // Result stage: holds a finished item until downstream takes it.
    logic      r_out_valid, n_out_valid;
    t_out_item r_out_item;

    t_out_item result;
    logic      out_free;
    logic      fire;
    logic      in_take;

    // The result stage can take a new item when it is empty or being drained
    // this cycle. The item in the input stage is processed exactly then, so
    // the field state advances once per processed item, in arrival order.
    assign out_free = !r_out_valid || !i_stall;
    assign fire     = r_in_valid && out_free;

    // Upstream waits only while an item is stuck in the input stage.
    assign o_stall  = r_in_valid && !out_free;
    assign in_take  = i_valid && !o_stall;

    ctfe_editor u_editor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_comb begin
        n_in_valid  = in_take || (r_in_valid && !fire);
        n_out_valid = fire || (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers load only on their stage's transfer.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item <= i_item;
        end
        if (fire) begin
            r_out_item <= result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

    `ASSERT_PROP(a_fire_fills_result, fire |=> r_out_valid,
                 "processed item did not reach result stage")
    `ASSERT_NEVER(a_stall_without_item, o_stall && !r_in_valid,
                  "upstream stalled with empty input stage")
    `ASSERT_PROP(a_no_commit_clean,
                 (r_out_valid && !r_out_item.committed) |->
                 (r_out_item.committed_unit == UNIT_YEAR &&
                  r_out_item.committed_value == '0),
                 "commit fields set without a commit")
    `ASSERT_PROP(a_enter_advances,
                 (r_out_valid && r_out_item.committed &&
                  r_out_item.committed_unit != UNIT_SECOND) |->
                 (r_out_item.selected_unit == r_out_item.committed_unit + 3'd1),
                 "commit did not advance the selection")

endmodule

// ===== verif/calendar_time_field_editor_tb.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Calendar time field editor testbench
// Drives button items into the editor through a table of directed cases and
// then a long random run of load, step and enter sequences. A scoreboard
// predicts every result from its own copy of the working and committed fields
// and checks each result item field by field, with random idling on both
// sides and one long receiver hold-off that backs the editor up.
// -----------------------------------------------------------------------------
module calendar_time_field_editor_tb;

    import ctfe_pkg::*;

    localparam int RANDOM_ITEMS = 530;
    localparam int HOLD_CYCLES  = 80;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    // Field limits in unit order: year, month, date, weekday, hour, minute, second.
    localparam t_value FIELD_MAX [7] = '{7'd99, 7'd12, 7'd31, 7'd7, 7'd23, 7'd59, 7'd59};
    localparam t_value FIELD_MIN [7] = '{7'd0, 7'd1, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0};
    localparam t_value MONTH_DAYS [12] = '{7'd31, 7'd28, 7'd31, 7'd30, 7'd31, 7'd30,
                                           7'd31, 7'd31, 7'd30, 7'd31, 7'd30, 7'd31};

    // One row of the directed table. When typed is set, exp holds the result
    // written out by hand; otherwise the row is checked against the predictor.
    typedef struct {
        t_in_item  item;
        bit        typed;
        t_out_item exp;
    } t_row;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item  = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    // Shadow copy of the editor state used for prediction.
    t_value    work_val [7];
    t_value    commit_val [7];
    t_unit     cur_unit;

    t_out_item expected_results [$];
    t_row      dir_rows [$];
    t_out_item want;
    int        mismatch_count = 0;
    int        quiet_cycles   = 0;
    bit        idle_on        = 1'b1;
    bit        hold_req       = 1'b0;

    calendar_time_field_editor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int exp);
        if (got != exp) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp));
        end
    endtask

    // Days in a month under the year mod 4 leap rule. Month codes outside
    // one to twelve, as seen straight after reset, count as 31 days.
    function automatic t_value month_days(input t_value mon, input t_value yr);
        if (mon < 7'd1 || mon > 7'd12) begin
            return 7'd31;
        end
        if (mon == 7'd2 && yr[1:0] == 2'b00) begin
            return 7'd29;
        end
        return MONTH_DAYS[mon - 7'd1];
    endfunction

    // Applies one button item to the shadow state and returns the result item
    // the editor should produce for it.
    task automatic apply_button(input t_in_item it, output t_out_item res);
        t_value raw [7];
        t_value v;
        t_value md;
        t_unit  u;
        res = '0;
        case (it.mode)
            MODE_LOAD: begin
                raw = '{it.load_year, 7'(it.load_month), 7'(it.load_date),
                        7'(it.load_weekday), 7'(it.load_hour), 7'(it.load_minute),
                        7'(it.load_second)};
                // Load values are saturated into range; the date is taken as
                // is, even when it is past the length of the loaded month.
                for (int i = 0; i < 7; i++) begin
                    v = raw[i];
                    if (v < FIELD_MIN[i]) begin
                        v = FIELD_MIN[i];
                    end else if (v > FIELD_MAX[i]) begin
                        v = FIELD_MAX[i];
                    end
                    work_val[i]   = v;
                    commit_val[i] = v;
                end
                cur_unit = UNIT_YEAR;
            end
            MODE_UP, MODE_DOWN: begin
                u  = cur_unit;
                md = month_days(work_val[UNIT_MONTH], work_val[UNIT_YEAR]);
                v  = work_val[u];
                if (it.mode == MODE_UP) begin
                    v = (v >= FIELD_MAX[u]) ? 7'd0 : v + 7'd1;
                    if (u == UNIT_DATE && (v == 7'd0 || v > md)) begin
                        v = 7'd1;
                    end
                    if ((u == UNIT_WEEKDAY || u == UNIT_MONTH) && v == 7'd0) begin
                        v = 7'd1;
                    end
                end else begin
                    // Down from zero goes to the field maximum, and a step that
                    // lands on zero in a one-based field wraps to its top.
                    v = (v == 7'd0) ? FIELD_MAX[u] : v - 7'd1;
                    if (v == 7'd0) begin
                        if (u == UNIT_DATE) begin
                            v = md;
                        end else if (u == UNIT_WEEKDAY) begin
                            v = 7'd7;
                        end else if (u == UNIT_MONTH) begin
                            v = 7'd12;
                        end
                    end
                end
                work_val[u] = v;
                // A new month pulls the date down to that month's length.
                if (u == UNIT_MONTH) begin
                    md = month_days(work_val[UNIT_MONTH], work_val[UNIT_YEAR]);
                    if (work_val[UNIT_DATE] > md) begin
                        work_val[UNIT_DATE] = md;
                    end
                end
                // Stepping the year to a common year turns 29 February into the 28th.
                if (u == UNIT_YEAR && work_val[UNIT_MONTH] == 7'd2 &&
                    work_val[UNIT_DATE] == 7'd29 &&
                    month_days(7'd2, work_val[UNIT_YEAR]) < 7'd29) begin
                    work_val[UNIT_DATE] = 7'd28;
                end
            end
            default: begin
                u = cur_unit;
                commit_val[u]       = work_val[u];
                res.committed       = 1'b1;
                res.committed_unit  = u;
                res.committed_value = work_val[u];
                cur_unit = (u == UNIT_SECOND) ? UNIT_YEAR : u + 3'd1;
            end
        endcase
        res.selected_unit  = cur_unit;
        res.selected_value = work_val[cur_unit];
        res.working_date   = work_val[UNIT_DATE][4:0];
    endtask

    function automatic t_in_item button(input t_mode m, input int yr = 0, input int mo = 0,
                                        input int dt = 0, input int wd = 0, input int hr = 0,
                                        input int mn = 0, input int sc = 0);
        t_in_item it;
        it.mode         = m;
        it.load_year    = 7'(yr);
        it.load_month   = 4'(mo);
        it.load_date    = 5'(dt);
        it.load_weekday = 3'(wd);
        it.load_hour    = 5'(hr);
        it.load_minute  = 6'(mn);
        it.load_second  = 6'(sc);
        return it;
    endfunction

    // Random items are mostly steps and commits, with a load every dozen items
    // or so to start a fresh sequence. Loads are usually in range and often
    // aim at the end of February or at a date near the end of a month.
    function automatic t_in_item random_button();
        t_in_item    it;
        logic [63:0] raw;
        int          pick;
        raw  = {$urandom(), $urandom()};
        it   = raw[$bits(t_in_item)-1:0];
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            it.mode = MODE_LOAD;
            pick = $urandom_range(0, 9);
            if (pick >= 2) begin
                it.load_year    = 7'($urandom_range(0, 99));
                it.load_month   = 4'($urandom_range(1, 12));
                it.load_date    = 5'($urandom_range(1, 31));
                it.load_weekday = 3'($urandom_range(1, 7));
                it.load_hour    = 5'($urandom_range(0, 23));
                it.load_minute  = 6'($urandom_range(0, 59));
                it.load_second  = 6'($urandom_range(0, 59));
                if (pick <= 4) begin
                    it.load_month = MONTH_FEB;
                    it.load_date  = 5'($urandom_range(28, 29));
                end else if (pick <= 6) begin
                    it.load_date = 5'($urandom_range(28, 31));
                end
            end
        end else if (pick < 44) begin
            it.mode = MODE_UP;
        end else if (pick < 74) begin
            it.mode = MODE_DOWN;
        end else begin
            it.mode = MODE_ENTER;
        end
        return it;
    endfunction

    // Offers one item, possibly after a short idle gap, holds it until the
    // editor takes it, then records the result it should produce.
    task automatic send_button(input t_in_item it, input bit typed, input t_out_item typed_res);
        t_out_item res;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        do @(posedge i_clk); while (o_stall);
        apply_button(it, res);
        expected_results.push_back(typed ? typed_res : res);
    endtask

    // Receiver side: random stall bursts while idling is on, plus one long
    // hold-off on request so the editor fills up and stalls its input.
    initial begin
        wait (i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // Scoreboard: every accepted result is matched against the oldest
    // expectation, field by field.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result item with no expectation pending");
            end else begin
                want = expected_results.pop_front();
                compare_field("selected_unit", o_item.selected_unit, want.selected_unit);
                compare_field("selected_value", o_item.selected_value, want.selected_value);
                compare_field("working_date", o_item.working_date, want.working_date);
                compare_field("committed", o_item.committed, want.committed);
                compare_field("committed_unit", o_item.committed_unit, want.committed_unit);
                compare_field("committed_value", o_item.committed_value,
                              want.committed_value);
            end
        end
    end

    // Watchdog: too many cycles without any item moving on either side means
    // the editor has hung.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("calendar_time_field_editor_tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        // Directed table. Rows with a result written out start from the reset
        // state or are loads; the rest use the predictor.
        // Stepping from reset: year wraps both ways, month wraps from zero.
        dir_rows.push_back('{button(MODE_DOWN), 1'b1,
                             t_out_item'{UNIT_YEAR, 7'd99, 5'd0, 1'b0, UNIT_YEAR, 7'd0}});
        dir_rows.push_back('{button(MODE_UP), 1'b1,
                             t_out_item'{UNIT_YEAR, 7'd0, 5'd0, 1'b0, UNIT_YEAR, 7'd0}});
        dir_rows.push_back('{button(MODE_ENTER), 1'b1,
                             t_out_item'{UNIT_MONTH, 7'd0, 5'd0, 1'b1, UNIT_YEAR, 7'd0}});
        dir_rows.push_back('{button(MODE_DOWN), 1'b1,
                             t_out_item'{UNIT_MONTH, 7'd12, 5'd0, 1'b0, UNIT_YEAR, 7'd0}});
        dir_rows.push_back('{button(MODE_UP), 1'b1,
                             t_out_item'{UNIT_MONTH, 7'd1, 5'd0, 1'b0, UNIT_YEAR, 7'd0}});
        dir_rows.push_back('{button(MODE_ENTER), 1'b1,
                             t_out_item'{UNIT_DATE, 7'd0, 5'd0, 1'b1, UNIT_MONTH, 7'd1}});
        // Down on a zero date goes to the field maximum.
        dir_rows.push_back('{button(MODE_DOWN), 1'b0, '0});
        // Loads with every field at its largest code and at zero saturate.
        dir_rows.push_back('{button(MODE_LOAD, 127, 15, 31, 7, 31, 63, 63), 1'b1,
                             t_out_item'{UNIT_YEAR, 7'd99, 5'd31, 1'b0, UNIT_YEAR, 7'd0}});
        dir_rows.push_back('{button(MODE_LOAD, 0, 0, 0, 0, 0, 0, 0), 1'b1,
                             t_out_item'{UNIT_YEAR, 7'd0, 5'd1, 1'b0, UNIT_YEAR, 7'd0}});
        // 29 February in a common year is accepted on load, kept when the year
        // steps into a leap year, and cut to the 28th on leaving it.
        dir_rows.push_back('{button(MODE_LOAD, 3, 2, 29, 7, 23, 59, 59), 1'b1,
                             t_out_item'{UNIT_YEAR, 7'd3, 5'd29, 1'b0, UNIT_YEAR, 7'd0}});
        dir_rows.push_back('{button(MODE_UP), 1'b0, '0});
        dir_rows.push_back('{button(MODE_UP), 1'b0, '0});
        // Stepping the month from January 31st clamps the date to February.
        dir_rows.push_back('{button(MODE_LOAD, 1, 1, 31, 1, 0, 0, 0), 1'b1,
                             t_out_item'{UNIT_YEAR, 7'd1, 5'd31, 1'b0, UNIT_YEAR, 7'd0}});
        dir_rows.push_back('{button(MODE_ENTER), 1'b0, '0});
        dir_rows.push_back('{button(MODE_UP), 1'b0, '0});
        dir_rows.push_back('{button(MODE_DOWN), 1'b0, '0});
        // April 31st on load, then date steps around the 30-day month length.
        dir_rows.push_back('{button(MODE_LOAD, 0, 4, 31, 4, 12, 30, 30), 1'b1,
                             t_out_item'{UNIT_YEAR, 7'd0, 5'd31, 1'b0, UNIT_YEAR, 7'd0}});
        dir_rows.push_back('{button(MODE_ENTER), 1'b0, '0});
        dir_rows.push_back('{button(MODE_ENTER), 1'b0, '0});
        dir_rows.push_back('{button(MODE_DOWN), 1'b0, '0});
        dir_rows.push_back('{button(MODE_UP), 1'b0, '0});
        dir_rows.push_back('{button(MODE_DOWN), 1'b0, '0});
        dir_rows.push_back('{button(MODE_ENTER), 1'b0, '0});
        dir_rows.push_back('{button(MODE_UP), 1'b0, '0});
        dir_rows.push_back('{button(MODE_ENTER), 1'b0, '0});

        for (int i = 0; i < 7; i++) begin
            work_val[i]   = '0;
            commit_val[i] = '0;
        end
        cur_unit = UNIT_YEAR;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) begin
            send_button(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].exp);
        end

        // Random part in phases of 64 items, idling on or off per phase. Partway into
        // one phase, idling stops for the rest of it and the long receiver hold-off
        // begins; the final stretch runs with no idling at all.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) begin
                idle_on = ($urandom_range(0, 2) != 0);
            end
            if (n == 200) begin
                idle_on  = 1'b0;
                hold_req = 1'b1;
            end
            if (n >= RANDOM_ITEMS - 100) begin
                idle_on = 1'b0;
            end
            send_button(random_button(), 1'b0, '0);
        end
        i_valid <= 1'b0;

        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("calendar_time_field_editor_tb: PASS");
        end else begin
            $display("calendar_time_field_editor_tb: FAIL");
        end
        $finish;
    end

endmodule
